// ----- sv/lpd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 1024;
  localparam int unsigned LEN_FIELD_BYTES  = 2;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned LEN_W            = 16;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              first_of_frame;
    logic              last_of_frame;
    logic              frame_error;
    logic [LEN_W-1:0]  frame_length;
  } result_t;

endpackage : lpd_pkg

`default_nettype wire

// ----- sv/lpd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lpd_front
  import lpd_pkg::*;
#(
  parameter int unsigned BufferBytes = BUFFER_BYTES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [BYTE_W-1:0] rx_byte_i,
  input  wire logic              q_ready_i,
  output logic                   q_push_o,
  output result_t                q_data_o
);

  localparam int unsigned Capacity = BufferBytes - LEN_FIELD_BYTES;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned CmpW     = LEN_W + 1;
  localparam logic [CmpW-1:0] CapV = CmpW'(Capacity);

  localparam logic [1:0] PH_LEN_HI  = 2'd0;
  localparam logic [1:0] PH_LEN_LO  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  logic [1:0]        phase_q, phase_d;
  logic [BYTE_W-1:0] len_hi_q, len_hi_d;
  logic [LEN_W-1:0]  decl_len_q, decl_len_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              accept;
  logic [CmpW-1:0]   cnt_ext;
  logic [CmpW-1:0]   decl_ext;
  result_t           res;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i & q_ready_i;
  assign cnt_ext    = CmpW'(count_q);
  assign decl_ext   = CmpW'(decl_len_q);

  always_comb begin
    phase_d    = phase_q;
    len_hi_d   = len_hi_q;
    decl_len_d = decl_len_q;
    count_d    = count_q;
    q_push_o   = 1'b0;
    res        = '0;
    if (accept) begin
      case (phase_q)
        PH_LEN_LO: begin
          decl_len_d = {len_hi_q, rx_byte_i};
          count_d    = '0;
          phase_d    = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          q_push_o         = 1'b1;
          res.frame_length = decl_len_q;
          if ((cnt_ext >= CapV) || (cnt_ext >= decl_ext)) begin
            // no room: abort frame, drop byte
            res.frame_error = 1'b1;
            phase_d    = PH_LEN_HI;
            len_hi_d   = '0;
            decl_len_d = '0;
            count_d    = '0;
          end else begin
            res.payload_byte   = rx_byte_i;
            res.first_of_frame = (count_q == '0);
            count_d            = count_q + 1'b1;
            if ((cnt_ext + CmpW'(1)) == decl_ext) begin
              res.last_of_frame = 1'b1;
              phase_d    = PH_LEN_HI;
              len_hi_d   = '0;
              decl_len_d = '0;
              count_d    = '0;
            end
          end
        end
        default: begin
          // high length byte; unused phase code behaves the same
          len_hi_d = rx_byte_i;
          phase_d  = PH_LEN_LO;
        end
      endcase
    end
  end

  assign q_data_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_LEN_HI;
      len_hi_q   <= '0;
      decl_len_q <= '0;
      count_q    <= '0;
    end else begin
      phase_q    <= phase_d;
      len_hi_q   <= len_hi_d;
      decl_len_q <= decl_len_d;
      count_q    <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_ext <= CapV)
    else $error("payload count beyond capacity");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_o && res.frame_error) |->
      (!res.first_of_frame && !res.last_of_frame && res.payload_byte == '0))
    else $error("error result carries payload marks");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_PAYLOAD) |-> (count_q == '0))
    else $error("count nonzero outside payload");

  a_last_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_o && (res.last_of_frame || res.frame_error)) |=> (phase_q == PH_LEN_HI))
    else $error("frame end did not return to idle");
`endif

endmodule : lpd_front

`default_nettype wire

// ----- sv/lpd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lpd_queue
  import lpd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t push_data_i,
  output logic         push_ready_o,
  input  wire logic    pop_i,
  output logic         pop_valid_o,
  output result_t      pop_data_o
);

  result_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wrap_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule : lpd_queue

`default_nettype wire

// ----- sv/lpd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lpd_back
  import lpd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    q_valid_i,
  input  wire result_t q_data_i,
  output logic         q_pop_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      out_data_o
);

  logic    valid_q;
  result_t data_q;

  // refill whenever the output register is empty or being drained
  assign q_pop_o     = q_valid_i & (~valid_q | out_ready_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      data_q <= q_data_i;
    end
  end

endmodule : lpd_back

`default_nettype wire

// ----- sv/length_prefixed_deframer.sv -----
// Length-prefixed frame deframer.
// Input channel (in_valid_i / in_ready_o / rx_byte_i) takes one received byte
// per item. Each frame is a 2-byte big-endian length followed by that many
// payload bytes. Length bytes produce no output item.
// Output channel (out_valid_o / out_ready_i) gives one item per payload byte,
// with first/last marks and the declared frame length. A byte with no room
// (zero-length frame, or beyond BufferBytes - 2 payload bytes) gives an item
// with frame_error set and zero payload; the frame is aborted and the block
// waits for a new length.
// Throughput: one item per cycle sustained while out_ready_i stays high, set
// by the classify/count step in the front end. A result is written into the
// queue at the edge that accepts its byte and then loaded into the output
// register, which waits while that register holds a result not yet taken.
// A two-entry queue sits between the front end and the output register, so
// the front keeps taking bytes while a result waits; when the receiver stalls
// long enough to fill the queue, in_ready_o drops.
// Reset (rst_ni low, asynchronous) returns to waiting for a high length byte
// and empties the queue and output register.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_deframer
  import lpd_pkg::*;
#(
  parameter int unsigned BufferBytes = BUFFER_BYTES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [BYTE_W-1:0] rx_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [BYTE_W-1:0]      payload_byte_o,
  output logic                   first_of_frame_o,
  output logic                   last_of_frame_o,
  output logic                   frame_error_o,
  output logic [LEN_W-1:0]       frame_length_o
);

  // front end -> queue
  logic    push;
  logic    push_ready;
  result_t push_data;
  // queue -> back end
  logic    pop;
  logic    pop_valid;
  result_t pop_data;
  result_t out_data;

  lpd_front #(
    .BufferBytes(BufferBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .q_ready_i  (push_ready),
    .q_push_o   (push),
    .q_data_o   (push_data)
  );

  lpd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data)
  );

  lpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_data_i    (pop_data),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign payload_byte_o   = out_data.payload_byte;
  assign first_of_frame_o = out_data.first_of_frame;
  assign last_of_frame_o  = out_data.last_of_frame;
  assign frame_error_o    = out_data.frame_error;
  assign frame_length_o   = out_data.frame_length;

endmodule : length_prefixed_deframer

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

// Checks the length-prefixed deframer at its default buffer size.
// A byte-level model of the deframer runs next to the block. Every accepted
// input byte is pushed through the model, and any result it gives is queued.
// A monitor pops the oldest queued result for each output handshake and
// compares it field by field.
// Inputs change on the falling edge. Outputs and handshakes are sampled on
// the rising edge.
// Both the byte source and the result sink pause at random. Stretches with no
// pauses at all are mixed in.
module testbench;
  import lpd_pkg::*;

  localparam int unsigned CAPACITY = BUFFER_BYTES_DEF - LEN_FIELD_BYTES;
  localparam int unsigned RANDOM_BYTES = 80;

  // Deframer phase, as the model tracks it. The spare code is never entered.
  typedef enum logic [1:0] {
    WAIT_LEN_HI = 2'd0,
    WAIT_LEN_LO = 2'd1,
    IN_PAYLOAD  = 2'd2,
    PHASE_SPARE = 2'd3
  } deframe_phase_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [BYTE_W-1:0] rx_byte_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [BYTE_W-1:0] payload_byte_o;
  logic              first_of_frame_o;
  logic              last_of_frame_o;
  logic              frame_error_o;
  logic [LEN_W-1:0]  frame_length_o;

  length_prefixed_deframer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .payload_byte_o  (payload_byte_o),
    .first_of_frame_o(first_of_frame_o),
    .last_of_frame_o (last_of_frame_o),
    .frame_error_o   (frame_error_o),
    .frame_length_o  (frame_length_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Model state, with the same reset values as the block.
  deframe_phase_e   dfr_phase = WAIT_LEN_HI;
  logic [BYTE_W-1:0] dfr_len_hi = '0;
  logic [LEN_W-1:0]  dfr_len = '0;
  int unsigned       dfr_count = 0;

  result_t     expected_results[$];
  int unsigned n_errors = 0;
  int unsigned bytes_sent = 0;
  bit          no_idle = 1'b0;   // set for stretches at full rate on both sides
  int unsigned sink_stall = 0;

  // Advances the model by one received byte and queues any result.
  function automatic void deframe_step(input logic [BYTE_W-1:0] b);
    result_t r;
    r = '0;
    case (dfr_phase)
      WAIT_LEN_LO: begin
        dfr_len   = {dfr_len_hi, b};
        dfr_count = 0;
        dfr_phase = IN_PAYLOAD;
      end
      IN_PAYLOAD: begin
        r.frame_length = dfr_len;
        // A zero-length frame, or a byte past capacity, has no room:
        // it gives an error result and the frame is dropped.
        if (dfr_count >= CAPACITY || dfr_count >= dfr_len) begin
          r.frame_error = 1'b1;
          dfr_phase  = WAIT_LEN_HI;
          dfr_len_hi = '0;
          dfr_len    = '0;
          dfr_count  = 0;
        end else begin
          r.payload_byte   = b;
          r.first_of_frame = (dfr_count == 0);
          dfr_count++;
          if (dfr_count == dfr_len) begin
            r.last_of_frame = 1'b1;
            dfr_phase  = WAIT_LEN_HI;
            dfr_len_hi = '0;
            dfr_len    = '0;
            dfr_count  = 0;
          end
        end
        expected_results.push_back(r);
      end
      default: begin
        // The spare phase code is handled like the wait for the high length byte.
        dfr_len_hi = b;
        dfr_phase  = WAIT_LEN_LO;
      end
    endcase
  endfunction

  // Pause lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_pause();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Payload bytes lean toward the extremes.
  function automatic logic [BYTE_W-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Number of bytes after the header that take a frame back to idle.
  function automatic int unsigned bytes_to_close(input logic [LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > CAPACITY) return CAPACITY + 1;
    return len;
  endfunction

  // Result sink: ready drops for random stretches.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      sink_stall = pick_pause();
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, expected none, actual byte %02h err %0b len %0h",
                 $time, payload_byte_o, frame_error_o, frame_length_o);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte_o));
        check_field("first_of_frame", 32'(want.first_of_frame), 32'(first_of_frame_o));
        check_field("last_of_frame", 32'(want.last_of_frame), 32'(last_of_frame_o));
        check_field("frame_error", 32'(want.frame_error), 32'(frame_error_o));
        check_field("frame_length", 32'(want.frame_length), 32'(frame_length_o));
      end
    end
  end

  // Sends one byte. Valid is held high across back-to-back bytes and only
  // lowered when a pause comes first.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned pause;
    pause = pick_pause();
    @(negedge clk_i);
    if (pause > 0) begin
      in_valid_i <= 1'b0;
      repeat (pause) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
    deframe_step(b);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic send_header(input logic [LEN_W-1:0] len);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  // A whole frame: header, then random payload until the deframer is idle again.
  task automatic send_frame(input logic [LEN_W-1:0] len);
    send_header(len);
    repeat (bytes_to_close(len)) send_byte(pick_byte());
  endtask

  // Short frames, zero-length frames and payload extremes.
  task automatic test_directed();
    send_header(16'd1);
    send_byte(8'h00);          // first and last on the same byte
    send_header(16'd0);
    send_byte(8'hFF);          // zero-length frame: error, byte dropped
    send_header(16'd3);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hA5);
    send_header(16'd2);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_header(16'd0);
    send_byte(8'h55);
    send_header(16'd1);        // back to normal after an error
    send_byte(8'hC3);
    release_input();
  endtask

  // A frame one byte over capacity: the full capacity passes with last
  // clear, then the next byte gives an error.
  task automatic test_capacity();
    send_frame(LEN_W'(CAPACITY + 1));
    release_input();
  endtask

  // Random frames with a sprinkling of broken ones.
  task automatic test_random();
    int unsigned start_count;
    int unsigned r;
    int unsigned len;
    int unsigned cut;
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      no_idle = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_frame(16'd0);
      end else if (r < 20) begin
        // Broken frame: a new header arrives mid-payload and is taken as data.
        len = $urandom_range(3, 16);
        cut = $urandom_range(0, len - 3);
        send_header(LEN_W'(len));
        repeat (cut) send_byte(pick_byte());
        send_header(LEN_W'($urandom_range(0, 16'hFFFF)));
        while (dfr_phase != WAIT_LEN_HI) send_byte(pick_byte());
      end else begin
        send_frame(LEN_W'($urandom_range(1, 20)));
      end
    end
    no_idle = 1'b0;
    release_input();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_capacity();
    test_random();

    while (expected_results.size() != 0) @(posedge clk_i);
    // Room for any stray result still in flight, past the longest sink pause.
    repeat (128) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- length_prefixed_deframer.f -----
sv/lpd_pkg.sv
sv/lpd_front.sv
sv/lpd_queue.sv
sv/lpd_back.sv
sv/length_prefixed_deframer.sv
bench/testbench.sv
